// ===== hw/rtl/dxtd_pkg.sv =====
// shared types, constants and arithmetic helpers for the dxt block decoder
package dxtd_pkg;

  // default depth of the block queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic [0:0] REG_BLOCK_FORMAT = 1'b0;

  // block_format codes
  localparam logic [1:0] FMT_DXT1 = 2'd0;
  localparam logic [1:0] FMT_DXT3 = 2'd1;
  localparam logic [1:0] FMT_DXT5 = 2'd2;

  // reciprocal multipliers for the constant divisions
  localparam logic [21:0] W5_MUL  = 22'd2156535;  // 255 * ceil(2^18 / 31)
  localparam logic [22:0] W6_MUL  = 23'd4244475;  // 255 * ceil(2^20 / 63)
  localparam logic [12:0] DIV7_MUL = 13'd4682;    // ceil(2^15 / 7)
  localparam logic [11:0] DIV5_MUL = 12'd3277;    // ceil(2^14 / 5)
  localparam logic [9:0]  DIV3_MUL = 10'd683;     // ceil(2^11 / 3)

  // how the alpha byte of a pixel is formed
  typedef enum logic [1:0] {
    ALPHA_OPAQUE,
    ALPHA_EXPLICIT,
    ALPHA_INTERP
  } alpha_mode_t;

  // one decoded block, ready for the pixel sequencer
  typedef struct packed {
    logic [3:0][31:0] pal;
    logic [7:0][7:0]  alv;
    alpha_mode_t      mode;
    logic [31:0]      cidx;
    logic [63:0]      aw;
  } blk_entry_t;

  // 5-bit channel to 8 bits, v*255/31 truncated
  function automatic logic [7:0] widen5(input logic [4:0] v);
    logic [26:0] p;
    p = 27'(v) * 27'(W5_MUL);
    return p[25:18];
  endfunction

  // 6-bit channel to 8 bits, v*255/63 truncated
  function automatic logic [7:0] widen6(input logic [5:0] v);
    logic [28:0] p;
    p = 29'(v) * 29'(W6_MUL);
    return p[27:20];
  endfunction

  // rgb565 to rgb888
  function automatic logic [23:0] widen565(input logic [15:0] c);
    return {widen5(c[15:11]), widen6(c[10:5]), widen5(c[4:0])};
  endfunction

  // s/7 for s up to 1785
  function automatic logic [7:0] div7(input logic [10:0] s);
    logic [23:0] p;
    p = 24'(s) * 24'(DIV7_MUL);
    return p[22:15];
  endfunction

  // s/5 for s up to 1275
  function automatic logic [7:0] div5(input logic [10:0] s);
    logic [22:0] p;
    p = 23'(s) * 23'(DIV5_MUL);
    return p[21:14];
  endfunction

  // s/3 for s up to 765
  function automatic logic [7:0] div3(input logic [9:0] s);
    logic [19:0] p;
    p = 20'(s) * 20'(DIV3_MUL);
    return p[18:11];
  endfunction

endpackage

// ===== hw/rtl/dxtd_front.sv =====
// front part: accepts blocks, expands endpoints and builds palette and alpha levels
module dxtd_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [63:0]          alpha_word,
  input  logic [63:0]          color_word,
  input  logic [1:0]           block_format,
  input  logic                 q_full,
  output logic                 q_push,
  output dxtd_pkg::blk_entry_t q_entry
);

  logic                  a_valid_r, a_valid_nxt;
  logic [63:0]           a_aw_r, a_cw_r;
  dxtd_pkg::alpha_mode_t a_mode_r, a_mode_nxt;

  logic                  b_valid_r, b_valid_nxt;
  logic [23:0]           b_e0_r, b_e1_r;
  logic                  b_gt_r;
  logic [63:0]           b_aw_r;
  logic [31:0]           b_cidx_r;
  dxtd_pkg::alpha_mode_t b_mode_r;

  logic                  b_adv;
  logic                  a_load;
  logic                  four_col;
  logic [7:0]            a0, a1;
  logic [7:0][7:0]       alv;
  logic [23:0]           mix21, mix12, mid;

  // stage handshakes
  assign q_push   = b_valid_r && !q_full;
  assign b_adv    = !b_valid_r || !q_full;
  assign in_ready = !a_valid_r || b_adv;
  assign a_load   = in_valid && in_ready;

  // format to alpha handling, unused code decodes as dxt5
  always_comb begin
    case (block_format)
      dxtd_pkg::FMT_DXT1: a_mode_nxt = dxtd_pkg::ALPHA_OPAQUE;
      dxtd_pkg::FMT_DXT3: a_mode_nxt = dxtd_pkg::ALPHA_EXPLICIT;
      dxtd_pkg::FMT_DXT5: a_mode_nxt = dxtd_pkg::ALPHA_INTERP;
      default:            a_mode_nxt = dxtd_pkg::ALPHA_INTERP;
    endcase
  end

  assign a_valid_nxt = in_ready ? in_valid : a_valid_r;
  assign b_valid_nxt = b_adv ? a_valid_r : b_valid_r;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
      b_valid_r <= b_valid_nxt;
    end
  end

  // stage a: capture the block
  always_ff @(posedge clk) begin
    if (a_load) begin
      a_aw_r   <= alpha_word;
      a_cw_r   <= color_word;
      a_mode_r <= a_mode_nxt;
    end
  end

  // stage b: expanded endpoints
  always_ff @(posedge clk) begin
    if (b_adv && a_valid_r) begin
      b_e0_r   <= dxtd_pkg::widen565(a_cw_r[15:0]);
      b_e1_r   <= dxtd_pkg::widen565(a_cw_r[31:16]);
      b_gt_r   <= a_cw_r[15:0] > a_cw_r[31:16];
      b_aw_r   <= a_aw_r;
      b_cidx_r <= a_cw_r[63:32];
      b_mode_r <= a_mode_r;
    end
  end

  // interpolated colors per channel
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      mix21[8*ch +: 8] = dxtd_pkg::div3(10'({b_e0_r[8*ch +: 8], 1'b0}) +
                                        10'(b_e1_r[8*ch +: 8]));
      mix12[8*ch +: 8] = dxtd_pkg::div3(10'(b_e0_r[8*ch +: 8]) +
                                        10'({b_e1_r[8*ch +: 8], 1'b0}));
      mid[8*ch +: 8]   = 8'((9'(b_e0_r[8*ch +: 8]) + 9'(b_e1_r[8*ch +: 8])) >> 1);
    end
  end

  // alpha levels
  assign a0 = b_aw_r[7:0];
  assign a1 = b_aw_r[15:8];

  always_comb begin
    alv[0] = a0;
    alv[1] = a1;
    for (int k = 2; k < 8; k++) begin
      if (a0 > a1) begin
        alv[k] = dxtd_pkg::div7(11'(8 - k) * 11'(a0) + 11'(k - 1) * 11'(a1));
      end else if (k < 6) begin
        alv[k] = dxtd_pkg::div5(11'(6 - k) * 11'(a0) + 11'(k - 1) * 11'(a1));
      end else if (k == 6) begin
        alv[k] = 8'h00;
      end else begin
        alv[k] = 8'hFF;
      end
    end
  end

  // palette and queue entry
  assign four_col = (b_mode_r != dxtd_pkg::ALPHA_OPAQUE) || b_gt_r;

  always_comb begin
    q_entry.pal[0] = {8'hFF, b_e0_r};
    q_entry.pal[1] = {8'hFF, b_e1_r};
    q_entry.pal[2] = four_col ? {8'hFF, mix21} : {8'hFF, mid};
    q_entry.pal[3] = four_col ? {8'hFF, mix12} : 32'h0000_0000;
    q_entry.alv    = alv;
    q_entry.mode   = b_mode_r;
    q_entry.cidx   = b_cidx_r;
    q_entry.aw     = b_aw_r;
  end

endmodule

// ===== hw/rtl/dxtd_queue.sv =====
// short block queue between front and back
module dxtd_queue #(
  parameter int DEPTH = dxtd_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  dxtd_pkg::blk_entry_t wr_entry,
  output logic                 full,
  input  logic                 pop,
  output logic                 head_valid,
  output dxtd_pkg::blk_entry_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  dxtd_pkg::blk_entry_t mem [DEPTH];
  logic [PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem[rd_ptr_r];

  // pointer and count updates
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_entry;
    end
  end

endmodule

// ===== hw/rtl/dxtd_back.sv =====
// back part: walks the sixteen pixels of the head block into the output register
module dxtd_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 head_valid,
  input  dxtd_pkg::blk_entry_t head,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [31:0]          out_argb,
  output logic [3:0]           out_index,
  output logic                 out_last
);

  logic [3:0]  cnt_r, cnt_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] argb_r;
  logic [3:0]  index_r;
  logic        last_r;
  logic        load;
  logic [1:0]  ci;
  logic [3:0]  nib;
  logic [2:0]  ai;
  logic [31:0] px;
  logic [7:0]  alpha;

  // a pixel moves into the output register when it is empty or being taken
  assign load = head_valid && (!out_valid_r || out_ready);
  assign pop  = load && (cnt_r == 4'd15);

  // pixel selection
  assign ci  = head.cidx[2*cnt_r +: 2];
  assign nib = head.aw[4*cnt_r +: 4];
  assign ai  = head.aw[16 + 3*cnt_r +: 3];
  assign px  = head.pal[ci];

  always_comb begin
    case (head.mode)
      dxtd_pkg::ALPHA_OPAQUE:   alpha = px[31:24];
      dxtd_pkg::ALPHA_EXPLICIT: alpha = {nib, nib};
      dxtd_pkg::ALPHA_INTERP:   alpha = head.alv[ai];
      default:                  alpha = px[31:24];
    endcase
  end

  assign cnt_nxt       = load ? cnt_r + 1'b1 : cnt_r;
  assign out_valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (load) begin
      argb_r  <= {alpha, px[23:0]};
      index_r <= cnt_r;
      last_r  <= (cnt_r == 4'd15);
    end
  end

  assign out_valid = out_valid_r;
  assign out_argb  = argb_r;
  assign out_index = index_r;
  assign out_last  = last_r;

endmodule

// ===== hw/rtl/dxt_block_decoder.sv =====
// top level of the dxt1/dxt3/dxt5 block decoder
// a block passes stage a, stage b, the queue and the output register before its first pixel is valid
// throughput: one pixel per cycle while out_tready is high and a block is queued, set by the pixel sequencer
// on an output stall the queue holds the block being walked plus one more, and the two
// front stages hold two more before in_tready drops
// reset (synchronous, rst_n low) empties the pipeline and queue and sets block_format to dxt1
module dxt_block_decoder #(
  parameter int QUEUE_DEPTH = dxtd_pkg::QUEUE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input blocks
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [127:0]                in_tdata,   // alpha_word, color_word
  // decoded pixels
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [39:0]                 out_tdata,  // pixel_argb, pixel_index, zero pad
  output logic                        out_tlast,  // last_pixel
  // configuration
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [dxtd_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [dxtd_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [dxtd_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                        cfg_pready
);

  logic [1:0]           block_format_r, block_format_nxt;
  logic                 cfg_wr;
  logic                 q_push, q_full, q_pop, q_head_valid;
  dxtd_pkg::blk_entry_t q_wr_entry, q_head;
  logic [31:0]          pix_argb;
  logic [3:0]           pix_index;

  // configuration register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr[2] == dxtd_pkg::REG_BLOCK_FORMAT);
  assign block_format_nxt = cfg_wr ? cfg_pwdata[1:0] : block_format_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_format_r <= dxtd_pkg::FMT_DXT1;
    end else begin
      block_format_r <= block_format_nxt;
    end
  end

  // register read
  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == dxtd_pkg::REG_BLOCK_FORMAT) begin
      cfg_prdata = {{(dxtd_pkg::CFG_DW-2){1'b0}}, block_format_r};
    end
  end

  dxtd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .alpha_word   (in_tdata[63:0]),
    .color_word   (in_tdata[127:64]),
    .block_format (block_format_r),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_entry      (q_wr_entry)
  );

  dxtd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .wr_entry   (q_wr_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  dxtd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_argb   (pix_argb),
    .out_index  (pix_index),
    .out_last   (out_tlast)
  );

  assign out_tdata = {4'b0000, pix_index, pix_argb};

endmodule

// ===== hw/rtl/dxtd_checker.sv =====
// port-level checks on the dxt block decoder, bound to the top level
module dxtd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tlast
);

  // a stalled pixel holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("pixel changed while stalled");

  // last flag marks pixel fifteen only
  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tdata[35:32] == 4'd15)))
    else $error("last flag does not match pixel index");

  // within a block, the next pixel follows at once with the next index
  a_next_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=>
      out_tvalid && (out_tdata[35:32] == $past(out_tdata[35:32]) + 4'd1))
    else $error("pixel sequence broken inside a block");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind dxt_block_decoder dxtd_checker u_dxtd_checker (.*);
